### sv/ffkc_pkg.sv
// Shared constants, types and codes of the farthest-first k-center unit.
package ffkc_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int DIST_BITS    = 16;
  localparam int IDX_BITS     = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
  localparam int K_BITS       = 11;
  localparam int ADDR_BITS    = 2 * IDX_BITS;

  // field widths on the ports
  localparam int VERTEX_FIELD_BITS = 10;
  localparam int DIST_FIELD_BITS   = 16;
  localparam int COUNT_FIELD_BITS  = 11;

  localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

  // request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // search modes
  localparam logic MODE_SINGLE = 1'b0;
  localparam logic MODE_BEST   = 1'b1;

  // register indexes
  localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [1:0] REG_CENTER_COUNT = 2'd1;
  localparam logic [1:0] REG_SEARCH_MODE  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FINISH
  } eng_state_t;

  // run parameters handed to the engine
  typedef struct packed {
    logic [CNT_BITS-1:0]          n;
    logic [K_BITS-1:0]            k;
    logic                         mode;
    logic [VERTEX_FIELD_BITS-1:0] start;
  } run_cmd_t;

  // result handed back by the engine
  typedef struct packed {
    logic                 valid;
    logic [DIST_BITS-1:0] radius;
    logic [IDX_BITS-1:0]  best_start;
  } run_res_t;

endpackage

### sv/farthest_first_k_center_unit.sv
// Top level: configuration registers, distance matrix memory, engine and output register.
// Load: one transfer per cycle while the engine is idle, written to the matrix memory at
// the edge of its transfer. Run: each pass for a center reads one matrix column from the
// matrix memory port, one entry per cycle; at most k passes per start; best-start mode
// runs n starts, and no request is taken until the result enters the output register.
// Reset (rst, synchronous) clears control state, sets vertex_count and center_count to 1
// and search_mode to single start; matrix undefined.
module farthest_first_k_center_unit (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // row_index[9:0], col_index[19:10], entry_distance[35:20],
                                // start_vertex[45:36], zero[47:46]
  input  logic        s_tuser,  // req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // radius[15:0], best_start[25:16], zero[31:26]
);

  localparam int IB = ffkc_pkg::IDX_BITS;
  localparam int CB = ffkc_pkg::CNT_BITS;
  localparam int DB = ffkc_pkg::DIST_BITS;
  localparam int CF = ffkc_pkg::COUNT_FIELD_BITS;
  localparam int VF = ffkc_pkg::VERTEX_FIELD_BITS;

  logic [CF-1:0] vertex_count;
  logic [CF-1:0] center_count;
  logic          search_mode;

  logic [VF-1:0] row_index;
  logic [VF-1:0] col_index;
  logic [15:0]   entry_distance;
  logic [VF-1:0] start_vertex;

  logic                         in_xfer;
  logic                         load_we;
  logic [ffkc_pkg::ADDR_BITS-1:0] load_addr;
  logic [ffkc_pkg::ADDR_BITS-1:0] dist_raddr;
  logic [DB-1:0]                dist_rdata;
  logic                         busy;
  ffkc_pkg::run_cmd_t           cmd;
  ffkc_pkg::run_res_t           res;
  logic                         res_taken;
  logic [15:0]                  out_radius;
  logic [VF-1:0]                out_start;

  // unpack the request
  assign row_index      = s_tdata[9:0];
  assign col_index      = s_tdata[19:10];
  assign entry_distance = s_tdata[35:20];
  assign start_vertex   = s_tdata[45:36];

  // configuration writes
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CF'(1);
      center_count <= CF'(1);
      search_mode  <= ffkc_pkg::MODE_SINGLE;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        ffkc_pkg::REG_VERTEX_COUNT: vertex_count <= pwdata[CF-1:0];
        ffkc_pkg::REG_CENTER_COUNT: center_count <= pwdata[CF-1:0];
        ffkc_pkg::REG_SEARCH_MODE:  search_mode  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (paddr[3:2])
      ffkc_pkg::REG_VERTEX_COUNT: prdata = 32'(vertex_count);
      ffkc_pkg::REG_CENTER_COUNT: prdata = 32'(center_count);
      ffkc_pkg::REG_SEARCH_MODE:  prdata = 32'(search_mode);
      default:                    prdata = '0;
    endcase
  end

  // accept requests while the engine is idle
  assign s_tready = !busy;
  assign in_xfer  = s_tvalid && s_tready;

  // load path into the matrix memory, out-of-range positions dropped
  assign load_we = in_xfer && (s_tuser == ffkc_pkg::REQ_LOAD)
                   && (32'(row_index) < 32'(ffkc_pkg::MAX_VERTICES))
                   && (32'(col_index) < 32'(ffkc_pkg::MAX_VERTICES));
  assign load_addr = {IB'(row_index), IB'(col_index)};

  ffkc_ram #(
    .WIDTH(DB),
    .DEPTH(ffkc_pkg::MAX_VERTICES * ffkc_pkg::MAX_VERTICES)
  ) u_dist_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(load_addr),
    .wdata(DB'(entry_distance)),
    .raddr(dist_raddr),
    .rdata(dist_rdata)
  );

  // saturate the counts for the run
  always_comb begin
    if (vertex_count == '0) begin
      cmd.n = CB'(1);
    end else if (32'(vertex_count) > 32'(ffkc_pkg::MAX_VERTICES)) begin
      cmd.n = CB'(ffkc_pkg::MAX_VERTICES);
    end else begin
      cmd.n = CB'(vertex_count);
    end
    cmd.k     = (center_count == '0) ? ffkc_pkg::K_BITS'(1) : ffkc_pkg::K_BITS'(center_count);
    cmd.mode  = search_mode;
    cmd.start = start_vertex;
  end

  ffkc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (in_xfer && (s_tuser == ffkc_pkg::REQ_RUN)),
    .cmd       (cmd),
    .busy      (busy),
    .dist_raddr(dist_raddr),
    .dist_rdata(dist_rdata),
    .res       (res),
    .res_taken (res_taken)
  );

  // output register: take the result when the slot is free
  assign res_taken = res.valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_taken) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_taken) begin
      out_radius <= 16'(res.radius);
      out_start  <= VF'(res.best_start);
    end
  end

  assign m_tdata = {6'b0, out_start, out_radius};

endmodule

### sv/ffkc_ram.sv
// Generic single-port-write, registered-read RAM.
module ffkc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ffkc_engine.sv
// Center selection sequencer with the nearest-center distance memory.
module ffkc_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  ffkc_pkg::run_cmd_t                  cmd,
  output logic                                busy,
  output logic [ffkc_pkg::ADDR_BITS-1:0]      dist_raddr,
  input  logic [ffkc_pkg::DIST_BITS-1:0]      dist_rdata,
  output ffkc_pkg::run_res_t                  res,
  input  logic                                res_taken
);

  localparam int IB = ffkc_pkg::IDX_BITS;
  localparam int CB = ffkc_pkg::CNT_BITS;
  localparam int DB = ffkc_pkg::DIST_BITS;
  localparam int KB = ffkc_pkg::K_BITS;

  ffkc_pkg::eng_state_t state, state_next;

  logic [CB-1:0] n, n_next;
  logic [KB-1:0] k, k_next;
  logic          mode, mode_next;
  logic [IB-1:0] j, j_next;
  logic [IB-1:0] center, center_next;
  logic [IB-1:0] pass_start, pass_start_next;
  logic [KB-1:0] pass_num, pass_num_next;
  logic          first_pass, first_pass_next;
  logic          v1;
  logic [IB-1:0] j1;
  logic [DB-1:0] far_d, far_d_next;
  logic [IB-1:0] far_idx, far_idx_next;
  logic          found, found_next;
  logic [DB-1:0] best_r, best_r_next;
  logic [IB-1:0] best_s, best_s_next;

  logic [DB-1:0] near_rdata;
  logic [DB-1:0] old_d;
  logic [DB-1:0] new_d;
  logic [IB-1:0] start_sat;
  logic          last_j;
  logic          last_p;
  logic          pass_done;

  // nearest-center distance per vertex
  ffkc_ram #(
    .WIDTH(DB),
    .DEPTH(ffkc_pkg::MAX_VERTICES)
  ) u_near_ram (
    .clk  (clk),
    .we   (v1),
    .waddr(j1),
    .wdata(new_d),
    .raddr(j),
    .rdata(near_rdata)
  );

  assign dist_raddr = {j, center};

  // relax one vertex against the newest center
  always_comb begin
    old_d = first_pass ? ffkc_pkg::DIST_INF : near_rdata;
    new_d = (dist_rdata < old_d) ? dist_rdata : old_d;
  end

  assign start_sat = (32'(cmd.start) >= 32'(cmd.n)) ? IB'(cmd.n - 1'b1) : IB'(cmd.start);
  assign last_j    = (CB'(j) == n - 1'b1);
  assign last_p    = (CB'(pass_start) == n - 1'b1);
  assign pass_done = (pass_num >= k) || !found;

  assign busy = (state != ffkc_pkg::ST_IDLE);

  always_comb begin
    res.valid      = (state == ffkc_pkg::ST_FINISH);
    res.radius     = best_r;
    res.best_start = best_s;
  end

  // state register and pipeline stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffkc_pkg::ST_IDLE;
      v1    <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= (state == ffkc_pkg::ST_SCAN);
    end
    j1         <= j;
    n          <= n_next;
    k          <= k_next;
    mode       <= mode_next;
    j          <= j_next;
    center     <= center_next;
    pass_start <= pass_start_next;
    pass_num   <= pass_num_next;
    first_pass <= first_pass_next;
    far_d      <= far_d_next;
    far_idx    <= far_idx_next;
    found      <= found_next;
    best_r     <= best_r_next;
    best_s     <= best_s_next;
  end

  // sequencer
  always_comb begin
    state_next      = state;
    n_next          = n;
    k_next          = k;
    mode_next       = mode;
    j_next          = j;
    center_next     = center;
    pass_start_next = pass_start;
    pass_num_next   = pass_num;
    first_pass_next = first_pass;
    far_d_next      = far_d;
    far_idx_next    = far_idx;
    found_next      = found;
    best_r_next     = best_r;
    best_s_next     = best_s;

    // track the first strict maximum of the relaxed distances
    if (v1 && (new_d > far_d)) begin
      far_d_next   = new_d;
      far_idx_next = j1;
      found_next   = 1'b1;
    end

    case (state)
      ffkc_pkg::ST_IDLE: begin
        if (start) begin
          n_next          = cmd.n;
          k_next          = cmd.k;
          mode_next       = cmd.mode;
          j_next          = '0;
          pass_num_next   = KB'(1);
          first_pass_next = 1'b1;
          far_d_next      = '0;
          found_next      = 1'b0;
          best_r_next     = ffkc_pkg::DIST_INF;
          best_s_next     = '0;
          if (cmd.mode == ffkc_pkg::MODE_SINGLE) begin
            pass_start_next = start_sat;
            center_next     = start_sat;
          end else begin
            pass_start_next = '0;
            center_next     = '0;
          end
          state_next = ffkc_pkg::ST_SCAN;
        end
      end
      ffkc_pkg::ST_SCAN: begin
        if (last_j) begin
          state_next = ffkc_pkg::ST_DRAIN;
        end else begin
          j_next = j + 1'b1;
        end
      end
      ffkc_pkg::ST_DRAIN: begin
        state_next = ffkc_pkg::ST_DECIDE;
      end
      ffkc_pkg::ST_DECIDE: begin
        j_next          = '0;
        far_d_next      = '0;
        found_next      = 1'b0;
        state_next      = ffkc_pkg::ST_SCAN;
        if (pass_done) begin
          // covering radius of this start is far_d
          if ((mode == ffkc_pkg::MODE_SINGLE) || (far_d < best_r)) begin
            best_r_next = far_d;
            best_s_next = pass_start;
          end
          if ((mode == ffkc_pkg::MODE_SINGLE) || last_p) begin
            state_next = ffkc_pkg::ST_FINISH;
          end else begin
            pass_start_next = pass_start + 1'b1;
            center_next     = pass_start + 1'b1;
            pass_num_next   = KB'(1);
            first_pass_next = 1'b1;
          end
        end else begin
          center_next     = far_idx;
          pass_num_next   = pass_num + 1'b1;
          first_pass_next = 1'b0;
        end
      end
      ffkc_pkg::ST_FINISH: begin
        if (res_taken) begin
          state_next = ffkc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ffkc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
